>>> rtl/core/tvt_pkg.sv
// Package for the trigram Viterbi tagger core: score types, constants,
// the controller state type and the saturating helper function.
// Depends on nothing; used by trigram_viterbi_tagger_core.
`timescale 1ns / 1ps

package tvt_pkg;

	typedef logic signed [15:0] score16_t;
	typedef logic signed [23:0] score24_t;
	typedef logic signed [25:0] sum26_t;

	localparam int NUM_BANKS = 7;
	localparam int BANK_W    = 64;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_PAIRS = 9;
	localparam int NUM_TRANS = 27;

	localparam logic [1:0] TAG_O     = 2'd0;
	localparam logic [1:0] TAG_GENE  = 2'd1;
	localparam logic [1:0] TAG_START = 2'd2;
	localparam logic [1:0] TAG_STOP  = 2'd2;

	localparam score16_t NEG_INF16 = 16'sh8000;
	localparam score24_t NEG_INF24 = 24'sh800000;
	localparam score24_t POS_MAX24 = 24'sh7fffff;

	localparam logic [BANK_W-1:0] TRANS_RESET = 64'h8000_8000_8000_8000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_FIN,
		ST_TRACE_RD,
		ST_TRACE_UPD,
		ST_EMIT
	} state_t;

	function automatic score24_t clamp24(input sum26_t s);
		score24_t r;
		if (s < sum26_t'(NEG_INF24)) begin
			r = NEG_INF24;
		end else if (s > sum26_t'(POS_MAX24)) begin
			r = POS_MAX24;
		end else begin
			r = s[23:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/tvt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing; instanced by the tagger core for its stored pointers and tags.
`timescale 1ns / 1ps

module tvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/trigram_viterbi_tagger_core.sv
// Top level of the two-tag trigram HMM Viterbi tagger.
// Depends on tvt_pkg and on tvt_ram for the pointer and tag memories.
// Channel table:
//   channel   direction  marker               payload
//   word      in         start && !busy       score_outside, score_gene, sentence_end
//   result    out        result_valid         tag, last_tag
//   config    in         cfg_we               cfg_index, cfg_wdata
// Words that end the sentence or fill the buffer close it; other words keep busy high for one cycle.
// After a closing word the core scores the nine final pairs in turn to pick the best one, walks
// the pointer memory back word by word (a read state, then an update state), then reads out the tags.
// Results appear in word order on consecutive cycles and cannot be held off.
// Reset clears the scores and trigram table at once; the memories need no clearing.
`timescale 1ns / 1ps

module trigram_viterbi_tagger_core #(
	parameter int MAX_WORDS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  tvt_pkg::score16_t                   score_outside,
	input  tvt_pkg::score16_t                   score_gene,
	input  logic                                sentence_end,
	output logic                                result_valid,
	output logic                                tag,
	output logic                                last_tag,
	input  logic                                cfg_we,
	input  logic [tvt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tvt_pkg::BANK_W-1:0]          cfg_wdata
);

	import tvt_pkg::*;

	localparam int CW = $clog2(MAX_WORDS + 1);
	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int START_PAIR = TAG_START * 3 + TAG_START;

	state_t state_q, state_d;

	logic [BANK_W-1:0] trans_q [NUM_BANKS];
	logic [NUM_BANKS*BANK_W-1:0] trans_flat;
	score24_t ps_q [NUM_PAIRS];
	score24_t cand_d [6][3];
	score24_t cand_s1 [6][3];
	logic end_s1;
	score24_t new_ps [NUM_PAIRS];
	logic [2*NUM_PAIRS-1:0] bp_row;
	logic [CW-1:0] word_count_q;
	logic last_word;

	logic [1:0] fin_j_q, fin_k_q;
	score24_t best_q;
	logic [1:0] a1_q, a2_q;
	logic [4:0] fin_e;
	logic [3:0] fin_p;
	score16_t fin_t;
	score24_t fin_f;
	score24_t fin_s;
	logic fin_better;
	logic fin_done;

	logic [AW-1:0] idx_q;
	logic [AW-1:0] last_idx;
	logic [3:0] tr_sel;
	logic [1:0] tr_ptr;

	logic bp_we;
	logic [2*NUM_PAIRS-1:0] bp_rdata;
	logic tag_we;
	logic [0:0] tag_rdata;
	logic out_vld_s1, out_last_s1;
	logic accept;

	assign accept = start && !busy;
	assign last_idx = AW'(word_count_q - 1'b1);

	always_comb begin
		for (int b = 0; b < NUM_BANKS; b++) begin
			trans_flat[b*BANK_W +: BANK_W] = trans_q[b];
		end
	end

	// Candidate sums for all next pairs, registered at the word transfer.
	always_comb begin
		score24_t prev;
		score16_t t;
		score16_t e;
		sum26_t s;
		for (int k = 0; k < 3; k++) begin
			for (int p = 0; p < 2; p++) begin
				for (int j = 0; j < 3; j++) begin
					prev = ps_q[j*3+k];
					t = trans_flat[16*(j*9+k*3+p) +: 16];
					e = (p == 1) ? score_gene : score_outside;
					s = sum26_t'(prev) + sum26_t'(t) + sum26_t'(e);
					if (prev == NEG_INF24 || t == NEG_INF16 || e == NEG_INF16) begin
						cand_d[k*2+p][j] = NEG_INF24;
					end else begin
						cand_d[k*2+p][j] = clamp24(s);
					end
				end
			end
		end
	end

	always_comb begin
		score24_t best;
		logic [1:0] b;
		for (int i = 0; i < NUM_PAIRS; i++) begin
			new_ps[i] = NEG_INF24;
		end
		bp_row = '0;
		for (int k = 0; k < 3; k++) begin
			for (int p = 0; p < 2; p++) begin
				best = NEG_INF24;
				b = TAG_O;
				for (int j = 0; j < 3; j++) begin
					if (cand_s1[k*2+p][j] > best) begin
						best = cand_s1[k*2+p][j];
						b = 2'(j);
					end
				end
				new_ps[k*3+p] = best;
				bp_row[2*(k*3+p) +: 2] = b;
			end
		end
	end

	assign last_word = end_s1 || ((word_count_q + 1'b1) == CW'(MAX_WORDS));

	assign fin_e = 5'({fin_j_q, 3'b000}) + 5'(fin_j_q) + 5'({fin_k_q, 1'b0})
		+ 5'(fin_k_q) + 5'(TAG_STOP);
	assign fin_p = 4'({fin_j_q, 1'b0}) + 4'(fin_j_q) + 4'(fin_k_q);
	assign fin_t = trans_flat[16*fin_e +: 16];
	assign fin_f = ps_q[fin_p];
	assign fin_s = clamp24(sum26_t'(fin_f) + sum26_t'(fin_t));
	assign fin_better = (fin_f != NEG_INF24) && (fin_t != NEG_INF16) && (fin_s > best_q);
	assign fin_done = (fin_j_q == 2'd2) && (fin_k_q == 2'd2);

	assign tr_sel = 4'({a1_q, 1'b0}) + 4'(a1_q) + 4'(a2_q);
	assign tr_ptr = bp_rdata[2*tr_sel +: 2];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				state_d = last_word ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				if (fin_done) begin
					state_d = ST_TRACE_RD;
				end
			end
			ST_TRACE_RD: begin
				state_d = ST_TRACE_UPD;
			end
			ST_TRACE_UPD: begin
				state_d = (idx_q == '0) ? ST_EMIT : ST_TRACE_RD;
			end
			ST_EMIT: begin
				if (idx_q == last_idx) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
		bp_we = (state_q == ST_ACC);
		tag_we = (state_q == ST_TRACE_RD);
	end

	tvt_ram #(
		.WIDTH (2*NUM_PAIRS),
		.DEPTH (MAX_WORDS),
		.AW    (AW)
	) u_bp_ram (
		.clk   (clk),
		.we    (bp_we),
		.waddr (word_count_q[AW-1:0]),
		.wdata (bp_row),
		.raddr (idx_q),
		.rdata (bp_rdata)
	);

	tvt_ram #(
		.WIDTH (1),
		.DEPTH (MAX_WORDS),
		.AW    (AW)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (idx_q),
		.wdata (a2_q[0]),
		.raddr (idx_q),
		.rdata (tag_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int b = 0; b < NUM_BANKS; b++) begin
				trans_q[b] <= TRANS_RESET;
			end
			for (int i = 0; i < NUM_PAIRS; i++) begin
				ps_q[i] <= (i == START_PAIR) ? '0 : NEG_INF24;
			end
			word_count_q <= '0;
			end_s1 <= 1'b0;
			fin_j_q <= '0;
			fin_k_q <= '0;
			best_q <= NEG_INF24;
			a1_q <= TAG_O;
			a2_q <= TAG_O;
			idx_q <= '0;
			out_vld_s1 <= 1'b0;
			out_last_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_BANKS))) begin
				trans_q[cfg_index] <= cfg_wdata;
			end
			out_vld_s1 <= (state_q == ST_EMIT);
			out_last_s1 <= (state_q == ST_EMIT) && (idx_q == last_idx);
			if (accept) begin
				end_s1 <= sentence_end;
			end
			case (state_q)
				ST_ACC: begin
					for (int i = 0; i < NUM_PAIRS; i++) begin
						ps_q[i] <= new_ps[i];
					end
					word_count_q <= word_count_q + 1'b1;
					fin_j_q <= '0;
					fin_k_q <= '0;
					best_q <= NEG_INF24;
					a1_q <= TAG_O;
					a2_q <= TAG_O;
				end
				ST_FIN: begin
					if (fin_better) begin
						best_q <= fin_s;
						a1_q <= fin_j_q;
						a2_q <= fin_k_q;
					end
					if (fin_k_q == 2'd2) begin
						fin_k_q <= '0;
						fin_j_q <= fin_j_q + 1'b1;
					end else begin
						fin_k_q <= fin_k_q + 1'b1;
					end
					if (fin_done) begin
						idx_q <= last_idx;
						for (int i = 0; i < NUM_PAIRS; i++) begin
							ps_q[i] <= (i == START_PAIR) ? '0 : NEG_INF24;
						end
					end
				end
				ST_TRACE_UPD: begin
					a2_q <= a1_q;
					a1_q <= tr_ptr;
					if (idx_q != '0) begin
						idx_q <= idx_q - 1'b1;
					end
				end
				ST_EMIT: begin
					if (idx_q == last_idx) begin
						word_count_q <= '0;
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cand_s1 <= cand_d;
		end
	end

	assign result_valid = out_vld_s1;
	assign tag = tag_rdata[0];
	assign last_tag = out_last_s1;

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == ST_EMIT))
		else $error("result strobe without a preceding read-out cycle");

	a_last_has_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_tag |-> result_valid)
		else $error("last tag marked outside a result transfer");

	a_accept_to_acc: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_ACC))
		else $error("word transfer did not start the score update");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		word_count_q <= CW'(MAX_WORDS))
		else $error("word count beyond buffer depth");

	a_trace_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRACE_UPD) |-> $past(state_q == ST_TRACE_RD))
		else $error("pointer update without a pointer read");

endmodule

>>> test/trigram_viterbi_tagger_core_test.sv
// Self-checking testbench for the two-tag trigram Viterbi tagger core.
// It runs directed and random sentences against its own decoder and checks every tag.
// Depends on tvt_pkg and trigram_viterbi_tagger_core.
`timescale 1ns / 1ps

module trigram_viterbi_tagger_core_test;

	localparam int MAX_WORDS     = 64;
	localparam int RANDOM_WORDS  = 460;
	localparam int PHASE_WORDS   = 60;
	localparam int SETTLE_CYCLES = 16;
	localparam int REPORT_LIMIT  = 10;
	localparam int TIMEOUT_NS    = 3_000_000;

	localparam int SCORE_FLOOR = tvt_pkg::NEG_INF24;
	localparam int SCORE_CEIL  = tvt_pkg::POS_MAX24;
	localparam int EMIT_NONE   = tvt_pkg::NEG_INF16;
	localparam int START_PAIR  = tvt_pkg::TAG_START * 3 + tvt_pkg::TAG_START;

	localparam logic [tvt_pkg::CFG_IDX_W-1:0] SPARE_INDEX = 3'd7;

	localparam tvt_pkg::score16_t E_NONE = 16'sh8000;
	localparam tvt_pkg::score16_t E_MIN  = 16'sh8001;
	localparam tvt_pkg::score16_t E_MAX  = 16'sh7fff;
	localparam tvt_pkg::score16_t E_ZERO = 16'sh0000;

	typedef enum {
		BANKS_RANDOM,
		BANKS_SMALL,
		BANKS_TOP,
		BANKS_BOTTOM,
		BANKS_BLANK,
		BANKS_ZERO
	} bank_mode_t;

	typedef struct packed {
		logic tag;
		logic last_tag;
	} word_tag_t;

	typedef struct packed {
		tvt_pkg::score16_t so;
		tvt_pkg::score16_t sg;
		logic              fin;
		logic              zero_first;
		logic              pinned;
		logic              pinned_tag;
	} directed_row_t;

	localparam directed_row_t PLAN [25] = '{
		'{E_ZERO, E_ZERO, 1'b1, 1'b0, 1'b1, 1'b0},
		'{E_MAX, E_NONE, 1'b1, 1'b0, 1'b1, 1'b0},
		'{E_NONE, E_MAX, 1'b1, 1'b0, 1'b1, 1'b0},
		'{E_MIN, E_MAX, 1'b0, 1'b0, 1'b0, 1'b0},
		'{E_MAX, E_MIN, 1'b0, 1'b0, 1'b0, 1'b0},
		'{E_NONE, E_NONE, 1'b1, 1'b0, 1'b0, 1'b0},
		'{E_ZERO, E_ZERO, 1'b1, 1'b1, 1'b1, 1'b0},
		'{E_NONE, E_ZERO, 1'b1, 1'b0, 1'b1, 1'b1},
		'{E_ZERO, E_NONE, 1'b1, 1'b0, 1'b1, 1'b0},
		'{E_MIN, E_MAX, 1'b1, 1'b0, 1'b1, 1'b1},
		'{E_MAX, E_MIN, 1'b1, 1'b0, 1'b1, 1'b0},
		'{E_NONE, E_NONE, 1'b1, 1'b0, 1'b1, 1'b0},
		'{16'sd100, -16'sd200, 1'b0, 1'b0, 1'b0, 1'b0},
		'{E_NONE, E_NONE, 1'b0, 1'b0, 1'b0, 1'b0},
		'{16'sd300, 16'sd300, 1'b0, 1'b0, 1'b0, 1'b0},
		'{E_ZERO, 16'sd1, 1'b1, 1'b0, 1'b0, 1'b0},
		'{E_MAX, E_MAX, 1'b0, 1'b0, 1'b0, 1'b0},
		'{E_MAX, E_MAX, 1'b0, 1'b0, 1'b0, 1'b0},
		'{E_MAX, E_MAX, 1'b0, 1'b0, 1'b0, 1'b0},
		'{E_MAX, E_MAX, 1'b1, 1'b0, 1'b0, 1'b0},
		'{E_NONE, E_MAX, 1'b0, 1'b0, 1'b0, 1'b0},
		'{E_MAX, E_NONE, 1'b0, 1'b0, 1'b0, 1'b0},
		'{E_NONE, E_MAX, 1'b1, 1'b0, 1'b0, 1'b0},
		'{E_MIN, E_MIN, 1'b0, 1'b0, 1'b0, 1'b0},
		'{E_MIN, E_MIN, 1'b1, 1'b0, 1'b0, 1'b0}
	};

	logic                                clk;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	tvt_pkg::score16_t                   score_outside;
	tvt_pkg::score16_t                   score_gene;
	logic                                sentence_end;
	logic                                result_valid;
	logic                                tag;
	logic                                last_tag;
	logic                                cfg_we;
	logic [tvt_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic [tvt_pkg::BANK_W-1:0]          cfg_wdata;

	logic [tvt_pkg::BANK_W-1:0] trans_banks [tvt_pkg::NUM_BANKS];
	int                         path_score [tvt_pkg::NUM_PAIRS];
	logic [1:0]                 prev2_store [MAX_WORDS][tvt_pkg::NUM_PAIRS];
	int                         words_taken;
	word_tag_t                  traced[$];
	word_tag_t                  tags_due[$];
	word_tag_t                  head_tag;
	int                         failures;
	int                         burst_left;

	trigram_viterbi_tagger_core #(
		.MAX_WORDS(MAX_WORDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.score_outside(score_outside),
		.score_gene(score_gene),
		.sentence_end(sentence_end),
		.result_valid(result_valid),
		.tag(tag),
		.last_tag(last_tag),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int trigram(input int e);
		tvt_pkg::score16_t v;
		v = trans_banks[e >> 2][16 * (e & 3) +: 16];
		return v;
	endfunction

	function automatic int saturate24(input int s);
		if (s < SCORE_FLOOR) begin
			return SCORE_FLOOR;
		end
		if (s > SCORE_CEIL) begin
			return SCORE_CEIL;
		end
		return s;
	endfunction

	function automatic logic [15:0] bank_entry(input bank_mode_t mode);
		case (mode)
			BANKS_RANDOM: return ($urandom_range(0, 7) == 0) ? E_NONE : 16'($urandom);
			BANKS_SMALL:  return ($urandom_range(0, 5) == 0) ? E_NONE :
				16'(256 * $urandom_range(0, 8) - 1024);
			BANKS_TOP:    return E_MAX;
			BANKS_BOTTOM: return E_MIN;
			BANKS_BLANK:  return E_NONE;
			default:      return E_ZERO;
		endcase
	endfunction

	function automatic tvt_pkg::score16_t emission();
		case ($urandom_range(0, 15))
			0:       return E_NONE;
			1:       return E_MAX;
			2:       return E_MIN;
			3, 4, 5: return tvt_pkg::score16_t'($urandom);
			default: return tvt_pkg::score16_t'($urandom_range(0, 4096) - 2048);
		endcase
	endfunction

	task automatic open_sentence();
		for (int i = 0; i < tvt_pkg::NUM_PAIRS; i++) begin
			path_score[i] = SCORE_FLOOR;
		end
		path_score[START_PAIR] = 0;
		words_taken = 0;
	endtask

	// Advances path scores by one word; at a sentence end or full buffer, traces the tags back.
	task automatic decode_word(input int so, input int sg, input logic fin);
		int         emis [2];
		int         fresh [tvt_pkg::NUM_PAIRS];
		logic [1:0] ptr [tvt_pkg::NUM_PAIRS];
		word_tag_t  rev [MAX_WORDS];
		int         prev, t, cand, best, f1, f2, step, n;
		emis[0] = so;
		emis[1] = sg;
		traced.delete();
		for (int i = 0; i < tvt_pkg::NUM_PAIRS; i++) begin
			fresh[i] = SCORE_FLOOR;
			ptr[i] = tvt_pkg::TAG_O;
		end
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) begin
				prev = path_score[j * 3 + k];
				if (prev == SCORE_FLOOR) continue;
				for (int p = 0; p < 2; p++) begin
					t = trigram(j * 9 + k * 3 + p);
					if (t == EMIT_NONE || emis[p] == EMIT_NONE) continue;
					cand = saturate24(prev + t + emis[p]);
					if (cand > fresh[k * 3 + p]) begin
						fresh[k * 3 + p] = cand;
						ptr[k * 3 + p] = 2'(j);
					end
				end
			end
		end
		for (int i = 0; i < tvt_pkg::NUM_PAIRS; i++) begin
			path_score[i] = fresh[i];
			prev2_store[words_taken][i] = ptr[i];
		end
		words_taken++;
		if (!fin && words_taken < MAX_WORDS) return;
		best = SCORE_FLOOR;
		f1 = tvt_pkg::TAG_O;
		f2 = tvt_pkg::TAG_O;
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) begin
				t = trigram(j * 9 + k * 3 + tvt_pkg::TAG_STOP);
				if (path_score[j * 3 + k] == SCORE_FLOOR || t == EMIT_NONE) continue;
				cand = saturate24(path_score[j * 3 + k] + t);
				if (cand > best) begin
					best = cand;
					f1 = j;
					f2 = k;
				end
			end
		end
		n = words_taken;
		for (int i = n; i > 0; i--) begin
			step = prev2_store[i - 1][f1 * 3 + f2];
			rev[i - 1] = '{tag: 1'(f2 & 1), last_tag: 1'(i == n)};
			f2 = f1;
			f1 = step;
		end
		for (int i = 0; i < n; i++) begin
			traced.insert(traced.size(), rev[i]);
		end
		open_sentence();
	endtask

	task automatic put_word(input tvt_pkg::score16_t so, input tvt_pkg::score16_t sg,
			input logic fin, input logic pinned = 1'b0, input logic pinned_tag = 1'b0);
		int        gap;
		word_tag_t due;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 8);
			@(negedge clk);
			start <= 1'b0;
			score_outside <= tvt_pkg::score16_t'($urandom);
			score_gene <= tvt_pkg::score16_t'($urandom);
			sentence_end <= 1'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		burst_left--;
		@(negedge clk);
		start <= 1'b1;
		score_outside <= so;
		score_gene <= sg;
		sentence_end <= fin;
		do @(posedge clk); while (busy);
		decode_word(so, sg, fin);
		if (pinned) begin
			due.tag = pinned_tag;
			due.last_tag = 1'b1;
			tags_due.insert(tags_due.size(), due);
		end else begin
			foreach (traced[i]) tags_due.insert(tags_due.size(), traced[i]);
		end
	endtask

	// Holds the sender back until every outstanding tag has been seen.
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (tags_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic load_banks(input bank_mode_t mode);
		logic [tvt_pkg::BANK_W-1:0] v;
		for (int bank = 0; bank < tvt_pkg::NUM_BANKS; bank++) begin
			for (int q = 0; q < 4; q++) begin
				v[16 * q +: 16] = bank_entry(mode);
			end
			if (bank == tvt_pkg::NUM_BANKS - 1) begin
				v[63:48] = 16'($urandom);
			end
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= 3'(bank);
			cfg_wdata <= v;
			trans_banks[bank] = v;
		end
		if ($urandom_range(0, 2) == 0) begin
			@(negedge clk);
			cfg_index <= SPARE_INDEX;
			cfg_wdata <= {$urandom, $urandom};
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (tags_due.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT) begin
					$display("Unexpected result: tag %0b last_tag %0b", tag, last_tag);
				end
			end else begin
				head_tag = tags_due.pop_front();
				if (head_tag.tag !== tag || head_tag.last_tag !== last_tag) begin
					failures++;
					if (failures <= REPORT_LIMIT) begin
						$display("Tag mismatch: expected tag %0b last_tag %0b, got tag %0b last_tag %0b",
							head_tag.tag, head_tag.last_tag, tag, last_tag);
					end
				end
			end
		end
	end

	initial begin
		int         phase, phase_words, random_words, len;
		logic       drop_flag;
		bank_mode_t mode;
		arst_n = 1'b0;
		start = 1'b0;
		score_outside = '0;
		score_gene = '0;
		sentence_end = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		failures = 0;
		burst_left = 0;
		for (int bank = 0; bank < tvt_pkg::NUM_BANKS; bank++) begin
			trans_banks[bank] = tvt_pkg::TRANS_RESET;
		end
		open_sentence();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (PLAN[r]) begin
			if (PLAN[r].zero_first) begin
				settle();
				load_banks(BANKS_ZERO);
			end
			put_word(PLAN[r].so, PLAN[r].sg, PLAN[r].fin, PLAN[r].pinned, PLAN[r].pinned_tag);
		end

		phase = 0;
		random_words = 0;
		while (random_words < RANDOM_WORDS) begin
			settle();
			mode = bank_mode_t'(phase % 6);
			load_banks(mode);
			phase_words = 0;
			while (phase_words < PHASE_WORDS) begin
				drop_flag = 1'($urandom);
				if (phase == 0 && phase_words == 0) begin
					len = MAX_WORDS;
					drop_flag = 1'b1;
				end else if ($urandom_range(0, 19) == 0) begin
					len = $urandom_range(MAX_WORDS - 4, MAX_WORDS);
				end else begin
					len = $urandom_range(1, 8);
				end
				for (int w = 0; w < len; w++) begin
					put_word(emission(), emission(),
						(w == len - 1) && !(len == MAX_WORDS && drop_flag));
				end
				phase_words += len;
			end
			random_words += phase_words;
			phase++;
		end

		settle();
		if (failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
